// File: rtl/core/pts_pkg.sv
// Shared types and constants of the periodic task tick scheduler.
`default_nettype none
package pts_pkg;

    localparam int PTS_NUM_SLOTS   = 8;
    localparam int PTS_MAX_REPORTS = 8;
    localparam int PTS_WIDTH_PER   = 16;

    typedef enum logic [2:0] {
        REQ_TICK    = 3'd0,
        REQ_ADD     = 3'd1,
        REQ_REMOVE  = 3'd2,
        REQ_ENABLE  = 3'd3,
        REQ_DISABLE = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic                    hand;
        logic                    en;
        logic [PTS_WIDTH_PER-1:0] per;
        logic [PTS_WIDTH_PER-1:0] cnt;
    } t_slot;

    typedef struct packed {
        logic shift;
        logic write;
        t_req op;
    } t_cell_ctl;

endpackage
`default_nettype wire

// File: rtl/core/pts_cell.sv
// One task slot of the rotating slot ring.
`default_nettype none
module pts_cell (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pts_pkg::t_cell_ctl i_ctl,
    input  wire logic              i_hit,
    input  wire logic [pts_pkg::PTS_WIDTH_PER-1:0] i_period,
    input  wire pts_pkg::t_slot    i_next,
    output pts_pkg::t_slot         o_slot
);
    import pts_pkg::*;

    t_slot r_slot;
    t_slot n_slot;

    // Take the neighbor's slot on a shift, else apply a direct command.
    always_comb begin
        n_slot = r_slot;
        if (i_ctl.shift) begin
            n_slot = i_next;
        end else if (i_ctl.write && i_hit) begin
            unique case (i_ctl.op)
                REQ_ADD: begin
                    n_slot.hand = 1'b1;
                    n_slot.en   = 1'b1;
                    n_slot.per  = i_period;
                    n_slot.cnt  = '0;
                end
                REQ_REMOVE: begin
                    n_slot.hand = 1'b0;
                    n_slot.en   = 1'b0;
                end
                REQ_ENABLE:  n_slot.en = 1'b1;
                REQ_DISABLE: n_slot.en = 1'b0;
                default:     n_slot = r_slot;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot.per <= n_slot.per;
        r_slot.cnt <= n_slot.cnt;
        if (!i_rst_n) begin
            r_slot.hand <= 1'b0;
            r_slot.en   <= 1'b0;
        end else begin
            r_slot.hand <= n_slot.hand;
            r_slot.en   <= n_slot.en;
        end
    end

    assign o_slot = r_slot;

endmodule
`default_nettype wire

// File: rtl/core/pts_head.sv
// Tick update of the slot at the head of the ring.
`default_nettype none
module pts_head (
    input  wire pts_pkg::t_slot i_slot,
    output pts_pkg::t_slot      o_slot,
    output logic                o_fire
);
    import pts_pkg::*;

    logic                     w_live;
    logic [PTS_WIDTH_PER-1:0] w_inc;

    assign w_live = i_slot.hand & i_slot.en;
    assign w_inc  = i_slot.cnt + PTS_WIDTH_PER'(1);
    assign o_fire = w_live && (w_inc >= i_slot.per);

    always_comb begin
        o_slot = i_slot;
        if (w_live) begin
            o_slot.cnt = o_fire ? '0 : w_inc;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/periodic_task_tick_scheduler.sv
// Add, remove, enable and disable give their word in the cycle after acceptance.
// A tick walks the slot ring one slot per cycle, then closes in S_FLUSH; the walk
// and the close stall only while a word waits on a full output register.
// Requests are taken only in idle, so a new tick waits until the last has closed;
// other requests one per cycle while the output register is free.
// Reset (synchronous, active low) clears slot handler/enable bits, counts and FSM;
// slot period and counter registers are loaded by add and need no reset.
`default_nettype none
module periodic_task_tick_scheduler #(
    parameter int NUM_SLOTS = pts_pkg::PTS_NUM_SLOTS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_req_type,
    input  wire logic [2:0]  i_slot_id,
    input  wire logic [15:0] i_period_ticks,
    input  wire logic        i_has_handler,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_fired,
    output logic [2:0]       o_fired_slot,
    output logic [2:0]       o_assigned_id,
    output logic             o_status,
    output logic [31:0]      o_tick_total,
    output logic [3:0]       o_slots_used,
    output logic             o_last
);
    import pts_pkg::*;

    // UW holds the used count up to NUM_SLOTS, IW walks the ring, CW compares ids.
    localparam int UW = $clog2(NUM_SLOTS + 1);
    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = (UW > 3) ? UW : 3;
    localparam int NW = $clog2(PTS_MAX_REPORTS + 1);

    t_state          r_state, n_state;
    logic [31:0]     r_tick, n_tick;
    logic [UW-1:0]   r_used, n_used;
    logic [IW-1:0]   r_step, n_step;
    logic [NW-1:0]   r_nfire, n_nfire;
    logic            r_pend_v, n_pend_v;
    logic [2:0]      r_pend_slot, n_pend_slot;

    logic            r_out_valid;
    logic            r_fired, n_fired;
    logic [2:0]      r_fslot, n_fslot;
    logic [2:0]      r_aid, n_aid;
    logic            r_status, n_status;
    logic            r_last, n_last;
    logic            w_out_load;

    logic            w_out_free;
    logic            w_in_acc;
    t_req            w_req;
    logic            w_reject;
    logic            w_id_ok;
    logic [CW-1:0]   w_addr;
    t_cell_ctl       w_ctl;

    t_slot           w_slot [NUM_SLOTS];
    t_slot           w_head_upd;
    logic            w_head_fire;
    logic            w_report;
    logic [NUM_SLOTS-1:0] w_hit;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_req      = t_req'(i_req_type);

    // Add rejects a null handler, a zero period or a full table.
    assign w_reject = !i_has_handler || (i_period_ticks == '0) || (r_used == UW'(NUM_SLOTS));
    // Ids beyond the added slots are ignored by remove, enable and disable.
    assign w_id_ok  = CW'(i_slot_id) < CW'(r_used);
    assign w_addr   = (w_req == REQ_ADD) ? CW'(r_used) : CW'(i_slot_id);

    // Ring of slot cells: cell 0 is the head, the updated head re-enters at the tail.
    pts_head u_head (
        .i_slot (w_slot[0]),
        .o_slot (w_head_upd),
        .o_fire (w_head_fire)
    );

    for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
        t_slot w_next;
        if (k == NUM_SLOTS - 1) begin : g_tail
            assign w_next = w_head_upd;
        end else begin : g_mid
            assign w_next = w_slot[k+1];
        end
        assign w_hit[k] = (w_addr == CW'(k));

        pts_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_hit    (w_hit[k]),
            .i_period (i_period_ticks),
            .i_next   (w_next),
            .o_slot   (w_slot[k])
        );
    end

    // Only the first few firings of one tick are reported; later slots still update.
    assign w_report = w_head_fire && (r_nfire < NW'(PTS_MAX_REPORTS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_tick   <= '0;
            r_used   <= '0;
            r_step   <= '0;
            r_nfire  <= '0;
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_tick   <= n_tick;
            r_used   <= n_used;
            r_step   <= n_step;
            r_nfire  <= n_nfire;
            r_pend_v <= n_pend_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_slot <= n_pend_slot;
    end

    // Next state, ring control and output word selection.
    always_comb begin
        n_state     = r_state;
        n_tick      = r_tick;
        n_used      = r_used;
        n_step      = r_step;
        n_nfire     = r_nfire;
        n_pend_v    = r_pend_v;
        n_pend_slot = r_pend_slot;
        w_ctl.shift = 1'b0;
        w_ctl.write = 1'b0;
        w_ctl.op    = w_req;
        w_out_load  = 1'b0;
        n_fired     = 1'b0;
        n_fslot     = '0;
        n_aid       = '0;
        n_status    = 1'b0;
        n_last      = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    case (w_req) inside
                        REQ_TICK: begin
                            n_tick   = r_tick + 32'd1;
                            n_step   = '0;
                            n_nfire  = '0;
                            n_pend_v = 1'b0;
                            n_state  = S_WALK;
                        end
                        REQ_ADD: begin
                            w_out_load = 1'b1;
                            n_status   = w_reject;
                            if (!w_reject) begin
                                w_ctl.write = 1'b1;
                                n_aid       = 3'(r_used);
                                n_used      = r_used + UW'(1);
                            end
                        end
                        REQ_REMOVE, REQ_ENABLE, REQ_DISABLE: begin
                            w_out_load  = 1'b1;
                            w_ctl.write = w_id_ok;
                        end
                        default: begin
                            w_out_load = 1'b1;
                        end
                    endcase
                end
            end
            S_WALK: begin
                // Hold the ring while a pending firing cannot leave.
                if (!(w_report && r_pend_v && !w_out_free)) begin
                    w_ctl.shift = 1'b1;
                    if (w_report) begin
                        if (r_pend_v) begin
                            w_out_load = 1'b1;
                            n_fired    = 1'b1;
                            n_fslot    = r_pend_slot;
                            n_last     = 1'b0;
                        end
                        n_pend_v    = 1'b1;
                        n_pend_slot = 3'(r_step);
                        n_nfire     = r_nfire + NW'(1);
                    end
                    n_step = r_step + IW'(1);
                    if (r_step == IW'(NUM_SLOTS - 1)) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                // Close the tick: last firing, or one empty word.
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_fired    = r_pend_v;
                    n_fslot    = r_pend_v ? r_pend_slot : 3'd0;
                    n_pend_v   = 1'b0;
                    n_nfire    = '0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register: load a new word when empty or being taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_fired  <= n_fired;
            r_fslot  <= n_fslot;
            r_aid    <= n_aid;
            r_status <= n_status;
            r_last   <= n_last;
        end
    end

    // Tick and used counts only change while the output register is free.
    assign o_out_valid   = r_out_valid;
    assign o_fired       = r_fired;
    assign o_fired_slot  = r_fslot;
    assign o_assigned_id = r_aid;
    assign o_status      = r_status;
    assign o_last        = r_last;
    assign o_tick_total  = r_tick;
    assign o_slots_used  = 4'(r_used);

    a_pend_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v == (r_nfire != '0))
        else $error("pending firing flag disagrees with firing count");

    a_nonlast_is_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> o_fired && !o_status)
        else $error("non-final word without a firing");

    a_tick_starts_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (w_req == REQ_TICK) |=> (r_state == S_WALK) && (r_step == '0))
        else $error("tick did not start a ring walk");

    a_used_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(NUM_SLOTS))
        else $error("used slot count beyond table size");

endmodule
`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the periodic task tick scheduler: directed and random requests.
`default_nettype none
module testbench;
    import pts_pkg::*;

    // Request codes the block must ignore; the package enum stops at disable.
    localparam logic [2:0] REQ_SPARE_LO = 3'd5;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;

    localparam int RANDOM_REQUESTS = 400;
    localparam int STEADY_FIRST    = 100;   // stretch where neither side idles
    localparam int STEADY_LAST     = 199;
    localparam int DRAIN_POINT     = 250;   // sender holds off here until all words are back
    localparam int CYCLE_LIMIT     = 200000;
    localparam int SETTLE_CYCLES   = 4 * (PTS_NUM_SLOTS + 1);
    localparam int MAX_REPORTS     = 20;

    typedef struct packed {
        logic        fired;
        logic [2:0]  fired_slot;
        logic [2:0]  assigned_id;
        logic        status;
        logic [31:0] tick_total;
        logic [3:0]  slots_used;
        logic        last;
    } t_sched_word;

    // Scoreboard: mirrors the slot table and queues the words each request should produce.
    class t_sched_scoreboard;
        bit          hand_bit [PTS_NUM_SLOTS];
        bit          en_bit   [PTS_NUM_SLOTS];
        bit [15:0]   period   [PTS_NUM_SLOTS];
        bit [15:0]   count    [PTS_NUM_SLOTS];
        int unsigned used;
        bit [31:0]   ticks;
        t_sched_word expected_words[$];
        int          errors;
        int          words_checked;
        int          firings_seen;
        int          adds_rejected;
        int          requests_taken;

        function t_sched_word make_word(bit fired, bit [2:0] fslot, bit [2:0] aid,
                                        bit status, bit last);
            t_sched_word w;
            w.fired       = fired;
            w.fired_slot  = fslot;
            w.assigned_id = aid;
            w.status      = status;
            w.tick_total  = ticks;
            w.slots_used  = 4'(used);
            w.last        = last;
            return w;
        endfunction

        function void accept_request(logic [2:0] req, logic [2:0] sid, logic [15:0] per_in,
                                     logic hand_in);
            int n;
            requests_taken++;
            case (req) inside
                REQ_TICK: begin
                    ticks = ticks + 1;
                    n = 0;
                    for (int i = 0; i < int'(used) && i < PTS_NUM_SLOTS; i++) begin
                        if (en_bit[i] && hand_bit[i]) begin
                            count[i] = count[i] + 1;
                            if (count[i] >= period[i]) begin
                                count[i] = 0;
                                if (n < PTS_MAX_REPORTS) begin
                                    expected_words.push_back(make_word(1, 3'(i), 0, 0, 0));
                                    n++;
                                end
                            end
                        end
                    end
                    if (n == 0) begin
                        expected_words.push_back(make_word(0, 0, 0, 0, 1));
                    end else begin
                        expected_words[$].last = 1'b1;
                    end
                end
                REQ_ADD: begin
                    if (!hand_in || per_in == 0 || used >= PTS_NUM_SLOTS) begin
                        adds_rejected++;
                        expected_words.push_back(make_word(0, 0, 0, 1, 1));
                    end else begin
                        hand_bit[used] = 1;
                        en_bit[used]   = 1;
                        period[used]   = per_in;
                        count[used]    = 0;
                        used           = used + 1;
                        expected_words.push_back(make_word(0, 0, 3'(used - 1), 0, 1));
                    end
                end
                REQ_REMOVE, REQ_ENABLE, REQ_DISABLE: begin
                    if (sid < used) begin
                        if (req == REQ_REMOVE) begin
                            hand_bit[sid] = 0;
                            en_bit[sid]   = 0;
                        end else begin
                            en_bit[sid] = (req == REQ_ENABLE);
                        end
                    end
                    expected_words.push_back(make_word(0, 0, 0, 0, 1));
                end
                default: begin
                    expected_words.push_back(make_word(0, 0, 0, 0, 1));
                end
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_word(t_sched_word got);
            t_sched_word want;
            if (expected_words.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected word: expected none, actual %h", $time, got);
                return;
            end
            want = expected_words.pop_front();
            words_checked++;
            if (got.fired === 1'b1) firings_seen++;
            compare_field("fired",       32'(want.fired),       32'(got.fired));
            compare_field("fired_slot",  32'(want.fired_slot),  32'(got.fired_slot));
            compare_field("assigned_id", 32'(want.assigned_id), 32'(got.assigned_id));
            compare_field("status",      32'(want.status),      32'(got.status));
            compare_field("tick_total",  want.tick_total,       got.tick_total);
            compare_field("slots_used",  32'(want.slots_used),  32'(got.slots_used));
            compare_field("last",        32'(want.last),        32'(got.last));
        endfunction
    endclass

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic [2:0]  i_req_type     = REQ_TICK;
    logic [2:0]  i_slot_id      = 3'd0;
    logic [15:0] i_period_ticks = 16'd0;
    logic        i_has_handler  = 1'b0;
    logic        i_out_ready    = 1'b0;
    wire logic        o_in_ready;
    wire logic        o_out_valid;
    wire logic        o_fired;
    wire logic [2:0]  o_fired_slot;
    wire logic [2:0]  o_assigned_id;
    wire logic        o_status;
    wire logic [31:0] o_tick_total;
    wire logic [3:0]  o_slots_used;
    wire logic        o_last;

    t_sched_scoreboard book = new();
    bit steady = 1'b0;
    int cycle_count = 0;

    periodic_task_tick_scheduler #(
        .NUM_SLOTS(PTS_NUM_SLOTS)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_req_type(i_req_type),
        .i_slot_id(i_slot_id),
        .i_period_ticks(i_period_ticks),
        .i_has_handler(i_has_handler),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_fired(o_fired),
        .o_fired_slot(o_fired_slot),
        .o_assigned_id(o_assigned_id),
        .o_status(o_status),
        .o_tick_total(o_tick_total),
        .o_slots_used(o_slots_used),
        .o_last(o_last)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Abort the run if the handshakes stop making progress.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d words still expected", $time,
                     book.expected_words.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: check the word taken at this edge, then pick the next ready level.
    // Both use values from before the edge, so event order within the step does not matter.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            book.check_word('{o_fired, o_fired_slot, o_assigned_id, o_status,
                              o_tick_total, o_slots_used, o_last});
        i_out_ready <= steady || ($urandom_range(99) >= 6);
    end

    // Present one request word and hold it until the block takes it. Every call starts
    // right after a rising edge, so valid gets a single assignment per time step.
    task automatic send_request(logic [2:0] req, logic [2:0] sid, logic [15:0] per,
                                logic hand);
        if (!steady && $urandom_range(99) < 6) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_req_type     <= req;
        i_slot_id      <= sid;
        i_period_ticks <= per;
        i_has_handler  <= hand;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        book.accept_request(req, sid, per, hand);
    endtask

    // Drop valid and wait until every expected word has come back.
    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (book.expected_words.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int pick;
        logic [15:0] per;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: requests on an empty table, rejected adds, firing, disable,
        // removal, enable of a removed slot and the ignored request codes.
        send_request(REQ_TICK,    3'd0, 16'd0,      1'b0);
        send_request(REQ_REMOVE,  3'd0, 16'd0,      1'b0);
        send_request(REQ_ENABLE,  3'd7, 16'd0,      1'b1);
        send_request(REQ_DISABLE, 3'd3, 16'd0,      1'b0);
        send_request(REQ_ADD,     3'd0, 16'd5,      1'b0);
        send_request(REQ_ADD,     3'd0, 16'd0,      1'b1);
        send_request(REQ_ADD,     3'd0, 16'd1,      1'b1);
        send_request(REQ_TICK,    3'd0, 16'd0,      1'b0);
        send_request(REQ_ADD,     3'd7, 16'hFFFF,   1'b1);
        send_request(REQ_ADD,     3'd0, 16'd2,      1'b1);
        send_request(REQ_TICK,    3'd0, 16'd0,      1'b0);
        send_request(REQ_TICK,    3'd0, 16'd0,      1'b0);
        send_request(REQ_DISABLE, 3'd0, 16'd0,      1'b0);
        send_request(REQ_TICK,    3'd0, 16'd0,      1'b0);
        send_request(REQ_ENABLE,  3'd0, 16'd0,      1'b0);
        send_request(REQ_REMOVE,  3'd1, 16'd0,      1'b0);
        send_request(REQ_ENABLE,  3'd1, 16'd0,      1'b0);
        send_request(REQ_TICK,    3'd0, 16'd0,      1'b0);
        for (int c = REQ_SPARE_LO; c <= REQ_SPARE_HI; c++)
            send_request(3'(c), 3'd7, 16'hFFFF, 1'b1);
        send_request(REQ_TICK,    3'd7, 16'hFFFF,   1'b1);
        hold_until_drained();

        // Random: mostly ticks and short-period adds so slots fire often; the table
        // fills up along the way, which exercises the full-table rejection.
        for (int k = 0; k < RANDOM_REQUESTS; k++) begin
            steady = (k >= STEADY_FIRST && k <= STEADY_LAST);
            if (k == DRAIN_POINT) hold_until_drained();
            pick = $urandom_range(99);
            if (pick < 55) begin
                send_request(REQ_TICK, 3'($urandom), 16'($urandom), 1'($urandom));
            end else if (pick < 70) begin
                if ($urandom_range(15) == 0)
                    per = 16'd0;
                else if ($urandom_range(7) == 0)
                    per = 16'($urandom);
                else
                    per = 16'($urandom_range(1, 6));
                send_request(REQ_ADD, 3'($urandom), per, ($urandom_range(9) != 0));
            end else if (pick < 82) begin
                send_request(REQ_ENABLE, 3'($urandom), 16'($urandom), 1'($urandom));
            end else if (pick < 93) begin
                send_request(REQ_DISABLE, 3'($urandom), 16'($urandom), 1'($urandom));
            end else if (pick < 95) begin
                send_request(REQ_REMOVE, 3'($urandom), 16'($urandom), 1'($urandom));
            end else begin
                send_request(3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI)), 3'($urandom),
                             16'($urandom), 1'($urandom));
            end
        end
        steady = 1'b0;

        // Wait for the tail, then give a tick walk time to show any stray word.
        i_in_valid <= 1'b0;
        while (book.expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run: %0d requests, %0d words checked, %0d firings, %0d adds rejected.",
                 book.requests_taken, book.words_checked, book.firings_seen,
                 book.adds_rejected);
        $display("Slots in use at end: %0d, ticks counted: %0d, mismatches: %0d.",
                 book.used, book.ticks, book.errors);
        if (book.errors == 0 && book.expected_words.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
